>>> hdl/sac_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sac_pkg
// Types and constants shared by the stick axis conditioner modules.
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegXGain   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegYGain   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLimit1  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLimit2  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegXKeys   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegYKeys   = 3'd5;

  localparam logic [15:0] GainReset  = 16'd4096;
  localparam logic [7:0]  LimitReset = 8'd128;

  // pipeline: 2 front stages, 1 merge stage, 1 square stage, 8 search stages
  localparam int unsigned NumStages = 12;
  localparam int unsigned SrchSteps = 8;

  typedef struct packed {
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic               x_neg_key;
    logic               x_pos_key;
    logic               y_neg_key;
    logic               y_pos_key;
    logic               first_hold;
    logic               second_hold;
  } in_t;

  typedef struct packed {
    logic signed [7:0] stick_x;
    logic signed [7:0] stick_y;
  } out_t;

  // merge stage to limit lane
  typedef struct packed {
    logic [13:0]       n;      // |a| * limit
    logic [15:0]       s;      // x*x + y*y
    logic signed [7:0] a;      // gained axis value
    logic              neg;
    logic              apply;
  } lim_req_t;

endpackage
`default_nettype wire

>>> hdl/sac_axis_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sac_axis_lane
// One axis front end: raw rescale or key pick, optional flip, then gain.
// ----------------------------------------------------------------------------
module sac_axis_lane (
  input  wire logic               clk_i,
  input  wire logic [1:0]         en_i,
  input  wire logic               from_keys_i,
  input  wire logic               flip_i,
  input  wire logic signed [15:0] raw_i,
  input  wire logic               neg_key_i,
  input  wire logic               pos_key_i,
  input  wire logic [15:0]        gain_i,
  output logic signed [7:0]       axis_o
);
  import sac_pkg::*;

  logic [15:0]       mag;
  logic [23:0]       num;
  logic [7:0]        q0;
  logic [16:0]       rem;
  logic [8:0]        q;
  logic signed [7:0] scaled;
  logic signed [7:0] picked;
  logic signed [7:0] pre_d, pre_q;
  logic [7:0]        amag;
  logic [23:0]       prod;
  logic [11:0]       gq;
  logic signed [7:0] gain_d, gain_q;

  // round(|v|*128/32767): floor((256|v| + 32767) / 65534)
  always_comb begin
    mag = raw_i[15] ? 16'(-raw_i) : raw_i;
    num = {mag, 8'd0} + 24'd32767;
    q0  = num[23:16];
    rem = {1'b0, num[15:0]} + {8'd0, q0, 1'b0};
    q   = {1'b0, q0} + ((rem >= 17'd65534) ? 9'd1 : 9'd0);
    if (raw_i[15]) begin
      scaled = (q > 9'd128) ? -8'sd128 : 8'(-q);
    end else begin
      scaled = (q > 9'd127) ? 8'sd127 : 8'(q);
    end
    if (from_keys_i) begin
      if (neg_key_i)      picked = -8'sd128;
      else if (pos_key_i) picked = 8'sd127;
      else                picked = 8'sd0;
    end else begin
      picked = scaled;
    end
    if (!flip_i)                    pre_d = picked;
    else if (picked == -8'sd128)    pre_d = 8'sd127;
    else if (picked == 8'sd127)     pre_d = -8'sd128;
    else                            pre_d = -picked;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) pre_q <= pre_d;
  end

  always_comb begin
    amag = pre_q[7] ? 8'(-pre_q) : pre_q;
    prod = amag * gain_i;
    gq   = prod[23:12];
    if (pre_q[7]) begin
      gain_d = (gq > 12'd128) ? -8'sd128 : 8'(-gq);
    end else begin
      gain_d = (gq > 12'd127) ? 8'sd127 : 8'(gq);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) gain_q <= gain_d;
  end

  assign axis_o = gain_q;

endmodule
`default_nettype wire

>>> hdl/sac_limit_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sac_limit_lane
// Exact trunc(|a|*L/sqrt(s)) by a pipelined bitwise search, one bit a stage.
// ----------------------------------------------------------------------------
module sac_limit_lane (
  input  wire logic                     clk_i,
  input  wire logic [sac_pkg::SrchSteps:0] en_i,
  input  wire sac_pkg::lim_req_t        req_i,
  output logic signed [7:0]             axis_o
);
  import sac_pkg::*;

  typedef struct packed {
    logic [27:0]       n2;
    logic [15:0]       s;
    logic [7:0]        q;
    logic [15:0]       q2;   // q*q kept alongside
    logic signed [7:0] a;
    logic              neg;
    logic              apply;
  } srch_t;

  srch_t st_q [SrchSteps+1];
  srch_t st0_d;

  always_comb begin
    st0_d       = '0;
    st0_d.n2    = req_i.n * req_i.n;
    st0_d.s     = req_i.s;
    st0_d.a     = req_i.a;
    st0_d.neg   = req_i.neg;
    st0_d.apply = req_i.apply;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) st_q[0] <= st0_d;
  end

  for (genvar j = 0; j < SrchSteps; j++) begin : g_step
    localparam int unsigned B = SrchSteps - 1 - j;
    logic [7:0]  t;
    logic [16:0] t2;
    logic [31:0] prod;
    srch_t       nxt;
    always_comb begin
      t    = st_q[j].q | 8'(1 << B);
      // (q + 2^B)^2 = q^2 + q*2^(B+1) + 2^(2B)
      t2   = {1'b0, st_q[j].q2} + (17'(st_q[j].q) << (B + 1)) + (17'd1 << (2 * B));
      prod = t2[15:0] * st_q[j].s;
      nxt  = st_q[j];
      if (prod <= {4'd0, st_q[j].n2}) begin
        nxt.q  = t;
        nxt.q2 = t2[15:0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i[j+1]) st_q[j+1] <= nxt;
    end
  end

  always_comb begin
    if (!st_q[SrchSteps].apply)  axis_o = st_q[SrchSteps].a;
    else if (st_q[SrchSteps].neg) axis_o = 8'(-st_q[SrchSteps].q);
    else                          axis_o = st_q[SrchSteps].q;
  end

endmodule
`default_nettype wire

>>> hdl/stick_axis_conditioner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stick_axis_conditioner
// Raw stick poll to signed 8-bit X/Y with gain and magnitude limit.
// ----------------------------------------------------------------------------
// A poll item enters every cycle when the output is not stalled. Two axis
// lanes rescale or pick from keys and apply the gain, a merge stage
// forms x^2+y^2 and selects the limit, and two limit lanes find
// trunc(|a|*L/sqrt(s)) one bit per stage over eight stages. Each stage has
// its own valid bit, so bubbles close up behind a stalled output.
// Configuration writes take effect at once and are meant for an idle block.
module stick_axis_conditioner (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sac_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [sac_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire sac_pkg::in_t                  in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output sac_pkg::out_t                      out_data_o
);
  import sac_pkg::*;

  logic [15:0] x_gain_q, y_gain_q;
  logic [7:0]  lim1_q, lim2_q;
  logic        x_keys_q, y_keys_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_gain_q <= GainReset;
      y_gain_q <= GainReset;
      lim1_q   <= LimitReset;
      lim2_q   <= LimitReset;
      x_keys_q <= 1'b0;
      y_keys_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegXGain:  x_gain_q <= cfg_data_i;
        RegYGain:  y_gain_q <= cfg_data_i;
        RegLimit1: lim1_q   <= cfg_data_i[7:0];
        RegLimit2: lim2_q   <= cfg_data_i[7:0];
        RegXKeys:  x_keys_q <= cfg_data_i[0];
        RegYKeys:  y_keys_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // per-stage valid and advance
  logic [NumStages-1:0] v_q, en;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NumStages-1];

  // hold flags ride along the front stages
  logic [1:0] hold0_q, hold1_q;
  always_ff @(posedge clk_i) begin
    if (en[0]) hold0_q <= {in_data_i.first_hold, in_data_i.second_hold};
    if (en[1]) hold1_q <= hold0_q;
  end

  logic signed [7:0] gx, gy;

  sac_axis_lane u_lane_x (
    .clk_i       (clk_i),
    .en_i        (en[1:0]),
    .from_keys_i (x_keys_q),
    .flip_i      (1'b0),
    .raw_i       (in_data_i.raw_x),
    .neg_key_i   (in_data_i.x_neg_key),
    .pos_key_i   (in_data_i.x_pos_key),
    .gain_i      (x_gain_q),
    .axis_o      (gx)
  );

  sac_axis_lane u_lane_y (
    .clk_i       (clk_i),
    .en_i        (en[1:0]),
    .from_keys_i (y_keys_q),
    .flip_i      (1'b1),
    .raw_i       (in_data_i.raw_y),
    .neg_key_i   (in_data_i.y_neg_key),
    .pos_key_i   (in_data_i.y_pos_key),
    .gain_i      (y_gain_q),
    .axis_o      (gy)
  );

  // merge: magnitude square and limit selection
  logic [7:0]  mx, my, lim;
  logic [15:0] s;
  logic        use_lim, apply;
  lim_req_t    rx_d, ry_d, rx_q, ry_q;

  always_comb begin
    mx = gx[7] ? 8'(-gx) : gx;
    my = gy[7] ? 8'(-gy) : gy;
    s  = 16'(mx * mx) + 16'(my * my);
    if (hold1_q[1]) begin
      use_lim = 1'b1;
      lim     = lim1_q;
    end else if (hold1_q[0]) begin
      use_lim = 1'b1;
      lim     = lim2_q;
    end else begin
      use_lim = 1'b0;
      lim     = lim1_q;
    end
    apply = use_lim && !lim[7] && (s != 16'd0);
    rx_d.n     = 14'(mx * lim[6:0]);
    rx_d.s     = s;
    rx_d.a     = gx;
    rx_d.neg   = gx[7];
    rx_d.apply = apply;
    ry_d.n     = 14'(my * lim[6:0]);
    ry_d.s     = s;
    ry_d.a     = gy;
    ry_d.neg   = gy[7];
    ry_d.apply = apply;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      rx_q <= rx_d;
      ry_q <= ry_d;
    end
  end

  sac_limit_lane u_lim_x (
    .clk_i  (clk_i),
    .en_i   (en[NumStages-1:3]),
    .req_i  (rx_q),
    .axis_o (out_data_o.stick_x)
  );

  sac_limit_lane u_lim_y (
    .clk_i  (clk_i),
    .en_i   (en[NumStages-1:3]),
    .req_i  (ry_q),
    .axis_o (out_data_o.stick_y)
  );

endmodule
`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives stick polls with random gaps and stalls, predicts each conditioned
// X/Y pair and checks results in order across several register settings.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sac_pkg::*;

  // expected stick pairs, in order, with the predictor's copy of the registers
  class stick_scoreboard;
    out_t pending[$];
    int   n_fail;
    int   n_checked;
    logic [15:0] gx, gy;
    logic [7:0]  lim1, lim2;
    logic        kx, ky;

    function new();
      gx = GainReset; gy = GainReset; lim1 = LimitReset; lim2 = LimitReset;
      kx = 0; ky = 0; n_fail = 0; n_checked = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
      case (idx)
        RegXGain:  gx = d;
        RegYGain:  gy = d;
        RegLimit1: lim1 = d[7:0];
        RegLimit2: lim2 = d[7:0];
        RegXKeys:  kx = d[0];
        RegYKeys:  ky = d[0];
        default: ;
      endcase
    endfunction

    function int rescale(logic signed [15:0] raw);
      int v, a, q;
      v = raw;
      a = (v < 0 ? -v : v) * 128;
      q = (2 * a + 32767) / 65534;
      q = v < 0 ? -q : q;
      if (q > 127) q = 127;
      if (q < -128) q = -128;
      return q;
    endfunction

    function int pick(logic from_keys, logic signed [15:0] raw, logic neg, logic pos);
      if (from_keys) begin
        if (neg) return -128;
        if (pos) return 127;
        return 0;
      end
      return rescale(raw);
    endfunction

    function int gained(int a, logic [15:0] g);
      longint m, q;
      m = longint'(a < 0 ? -a : a) * g;
      q = m >>> 12;
      if (a < 0) return q > 128 ? -128 : -int'(q);
      return q > 127 ? 127 : int'(q);
    endfunction

    function int limited(int a, longint lim, longint s);
      longint n, n2, t;
      int q;
      n = longint'(a < 0 ? -a : a) * lim;
      n2 = n * n;
      q = 0;
      for (int b = 128; b != 0; b >>= 1) begin
        t = q | b;
        if (t * t * s <= n2) q |= b;
      end
      return a < 0 ? -q : q;
    endfunction

    function void note_poll(in_t p);
      int x, y, nx;
      longint s;
      logic use_lim;
      logic [7:0] lim;
      out_t r;
      x = pick(kx, p.raw_x, p.x_neg_key, p.x_pos_key);
      y = pick(ky, p.raw_y, p.y_neg_key, p.y_pos_key);
      y = (y == -128) ? 127 : (y == 127) ? -128 : -y;
      x = gained(x, gx);
      y = gained(y, gy);
      use_lim = p.first_hold | p.second_hold;
      lim = p.first_hold ? lim1 : lim2;
      if (use_lim && lim < 128) begin
        s = x * x + y * y;
        if (s != 0) begin
          nx = limited(x, lim, s);
          y = limited(y, lim, s);
          x = nx;
        end
      end
      r.stick_x = x[7:0];
      r.stick_y = y[7:0];
      pending.push_back(r);
    endfunction

    function void check_pair(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d", $time, got.stick_x, got.stick_y);
        n_fail++;
        return;
      end
      want = pending.pop_front();
      n_checked++;
      if (got.stick_x !== want.stick_x) begin
        $display("%0t: stick_x mismatch expected %0d actual %0d", $time,
                 want.stick_x, got.stick_x);
        n_fail++;
      end
      if (got.stick_y !== want.stick_y) begin
        $display("%0t: stick_y mismatch expected %0d actual %0d", $time,
                 want.stick_y, got.stick_y);
        n_fail++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 0, in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o, out_ready_i = 0;
  out_t out_data_o;

  stick_axis_conditioner i_dut (.*);

  always #5 clk_i = ~clk_i;

  stick_scoreboard sb = new();
  int n_polls = 0;
  int idle_cycles = 0;
  int stall_mode = 0;   // 0 random, 1 long hold-off then random, 2 always ready
  bit hold_off = 0;
  bit stim_done = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // leaves valid high; the caller lowers it before any wait
  task automatic send_poll(in_t p, bit gaps);
    int g;
    if (gaps) begin
      g = gap_len();
      if (g > 0) begin
        in_valid_i <= 0;
        repeat (g) @(negedge clk_i);
      end
    end
    in_valid_i <= 1;
    in_data_i <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_poll(p);
    n_polls++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.set_reg(idx, d);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    @(negedge clk_i);
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (NumStages + 4) @(negedge clk_i);
  endtask

  function automatic in_t rand_poll();
    in_t p;
    p = in_t'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0: p.raw_x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: p.raw_y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2: begin
        p.raw_x = $urandom_range(0, 600) - 300;
        p.raw_y = $urandom_range(0, 600) - 300;
      end
      default: ;
    endcase
    return p;
  endfunction

  // receiver: random stalls, or a long counted hold-off, or always ready
  always @(negedge clk_i) begin
    if (hold_off) out_ready_i <= 0;
    else if (stall_mode == 2) out_ready_i <= 1;
    else out_ready_i <= ($urandom_range(0, 99) < 70);
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check_pair(out_data_o);
    if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    in_t p;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: field extremes, keys, flip corners, holds at reset limits
    p = '0; send_poll(p, 0);
    p.raw_x = 16'sh7fff; p.raw_y = 16'sh8000; send_poll(p, 0);
    p.raw_x = 16'sh8000; p.raw_y = 16'sh7fff; send_poll(p, 0);
    p.raw_x = 16'sh8001; p.raw_y = 16'sh0080; send_poll(p, 0);
    p.raw_x = 16'sh00ff; p.raw_y = -16'sh00ff; send_poll(p, 0);
    p = '1; send_poll(p, 0);
    p = '0; p.first_hold = 1; p.raw_x = 16'sh4000; send_poll(p, 0);
    p.first_hold = 0; p.second_hold = 1; send_poll(p, 0);
    drain();

    write_reg(RegXKeys, 1); write_reg(RegYKeys, 1);
    write_reg(RegLimit1, 64); write_reg(RegLimit2, 0);
    for (int k = 0; k < 16; k++) begin
      p = '0;
      {p.x_neg_key, p.x_pos_key, p.y_neg_key, p.y_pos_key} = k[3:0];
      p.first_hold = k[0]; p.second_hold = k[1];
      send_poll(p, 0);
    end
    drain();

    // random phases across register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(RegXGain, 16'hffff); write_reg(RegYGain, 0); end
        1: begin write_reg(RegXGain, 0); write_reg(RegYGain, 16'hffff); end
        2: begin write_reg(RegLimit1, 127); write_reg(RegLimit2, 255); end
        default: begin
          write_reg(RegXGain, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(2048, 8192));
          write_reg(RegYGain, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(2048, 8192));
          write_reg(RegLimit1, $urandom_range(0, 255));
          write_reg(RegLimit2, $urandom_range(0, 160));
        end
      endcase
      write_reg(RegXKeys, $urandom_range(0, 1));
      write_reg(RegYKeys, $urandom_range(0, 1));
      if (ph == 2) stall_mode = 1;
      if (ph == 5) stall_mode = 2;
      for (int i = 0; i < 175; i++) begin
        send_poll(rand_poll(), (ph != 5) && (i % 60 < 45));
        if (i == 100) begin
          in_valid_i <= 0;
          @(negedge clk_i);
          while (sb.pending.size() != 0) @(negedge clk_i);
        end
      end
      drain();
      stall_mode = 0;
    end
    stim_done = 1;
  end

  // long hold-off counted here while the sender keeps offering polls
  initial begin
    wait (stall_mode == 1);
    hold_off = 1;
    repeat (200) @(negedge clk_i);
    hold_off = 0;
  end

  initial begin
    wait (stim_done);
    $display("%0d polls sent, %0d pairs checked over gain, key-source and limit settings",
             n_polls, sb.n_checked);
    if (sb.n_fail == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> files.f
hdl/sac_pkg.sv
hdl/sac_axis_lane.sv
hdl/sac_limit_lane.sv
hdl/stick_axis_conditioner.sv
dv/testbench.sv
